// File: hw/rtl/lbic_pkg.sv
// Shared types, codes and reset constants for the LED bank with idle chaser.
`default_nettype none

package lbic_pkg;

  localparam int LBIC_NUM_LEDS = 8;

  localparam logic [15:0] START_PERIOD_RST = 16'd250;
  localparam logic [15:0] PERIOD_DEC_RST   = 16'd75;
  localparam logic [15:0] DEC_THRESH_RST   = 16'd100;
  localparam logic [15:0] MIN_PERIOD_RST   = 16'd50;
  localparam logic [3:0]  ACCEL_PASSES_RST = 4'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_PERIOD = 3'd0,
    CFG_PERIOD_DEC   = 3'd1,
    CFG_DEC_THRESH   = 3'd2,
    CFG_MIN_PERIOD   = 3'd3,
    CFG_ACCEL_PASSES = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    REQ_TICK       = 4'd0,
    REQ_ON         = 4'd1,
    REQ_OFF        = 4'd2,
    REQ_TOGGLE     = 4'd3,
    REQ_LOAD       = 4'd4,
    REQ_STATUS_ON  = 4'd5,
    REQ_STATUS_OFF = 4'd6,
    REQ_STATUS_TGL = 4'd7,
    REQ_IDLE_START = 4'd8,
    REQ_IDLE_STOP  = 4'd9
  } req_t;

  typedef struct packed {
    logic [15:0] start_period;
    logic [15:0] period_decrement;
    logic [15:0] decrement_threshold;
    logic [15:0] min_period;
    logic [3:0]  accel_passes;
  } cfg_t;

  typedef struct packed {
    logic [8:0] led_map;
    logic       idle_active;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/lbic_if.sv
// Valid/ready channel interfaces for request and result beats.
`default_nettype none

interface lbic_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] req_type;
  logic [7:0] front_mask;
  logic       activity;

  modport source (output valid, output req_type, output front_mask, output activity,
                  input ready);
  modport sink   (input valid, input req_type, input front_mask, input activity,
                  output ready);
endinterface

interface lbic_res_if;
  logic       valid;
  logic       ready;
  logic [8:0] led_map;
  logic       idle_active;

  modport source (output valid, output led_map, output idle_active, input ready);
  modport sink   (input valid, input led_map, input idle_active, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lbic_cfg_regs.sv
// Configuration register file for the chaser timing.
`default_nettype none

module lbic_cfg_regs
  import lbic_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_period        <= START_PERIOD_RST;
      cfg.period_decrement    <= PERIOD_DEC_RST;
      cfg.decrement_threshold <= DEC_THRESH_RST;
      cfg.min_period          <= MIN_PERIOD_RST;
      cfg.accel_passes        <= ACCEL_PASSES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_PERIOD: cfg.start_period        <= cfg_data;
        CFG_PERIOD_DEC:   cfg.period_decrement    <= cfg_data;
        CFG_DEC_THRESH:   cfg.decrement_threshold <= cfg_data;
        CFG_MIN_PERIOD:   cfg.min_period          <= cfg_data;
        CFG_ACCEL_PASSES: cfg.accel_passes        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lbic_core.sv
// LED state registers and combinational command / chaser update.
`default_nettype none

module lbic_core
  import lbic_pkg::*;
#(
  parameter int NUM_LEDS = LBIC_NUM_LEDS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [3:0] req_type,
  input  wire logic [7:0] front_mask,
  input  wire logic       activity,
  input  wire cfg_t       cfg,
  output res_t            res_next
);

  localparam int PW = $clog2(NUM_LEDS + 1);

  logic [7:0]    front_leds, front_leds_next;
  logic          status_lit, status_lit_next;
  logic          running, running_next;
  logic          fast_stage, fast_stage_next;
  logic [3:0]    pass_count, pass_count_next;
  logic [PW-1:0] led_position, led_position_next;
  logic [15:0]   tick_count, tick_count_next;
  logic [15:0]   step_period, step_period_next;
  logic          pending, pending_next;

  logic [15:0]   tc_inc;
  logic [PW-1:0] pos;
  logic [3:0]    pc_inc;

  always_comb begin
    front_leds_next   = front_leds;
    status_lit_next   = status_lit;
    running_next      = running;
    fast_stage_next   = fast_stage;
    pass_count_next   = pass_count;
    led_position_next = led_position;
    tick_count_next   = tick_count;
    step_period_next  = step_period;
    pending_next      = pending;
    tc_inc            = tick_count + 16'd1;
    pos               = led_position;
    pc_inc            = pass_count + 4'd1;

    unique case (req_type)
      REQ_TICK: begin
        pending_next = 1'b0;
        if (running) begin
          if (activity || pending) begin
            running_next    = 1'b0;
            front_leds_next = '0;
          end else if (tc_inc < step_period) begin
            tick_count_next = tc_inc;
          end else begin
            tick_count_next = '0;
            if (led_position >= PW'(NUM_LEDS)) begin
              pos = '0;
              if (!fast_stage) begin
                pass_count_next = pc_inc;
                if (step_period > cfg.decrement_threshold &&
                    cfg.period_decrement < step_period) begin
                  step_period_next = step_period - cfg.period_decrement;
                end else begin
                  step_period_next = cfg.min_period;
                end
                if (pc_inc >= cfg.accel_passes) begin
                  fast_stage_next  = 1'b1;
                  step_period_next = cfg.min_period;
                end
              end
            end
            front_leds_next   = (32'(pos) < 32'd8) ? (8'd1 << pos) : 8'd0;
            led_position_next = pos + PW'(1);
          end
        end
      end
      REQ_ON:         front_leds_next = front_leds | front_mask;
      REQ_OFF:        front_leds_next = front_leds & ~front_mask;
      REQ_TOGGLE:     front_leds_next = front_leds ^ front_mask;
      REQ_LOAD:       front_leds_next = front_mask;
      REQ_STATUS_ON:  status_lit_next = 1'b1;
      REQ_STATUS_OFF: status_lit_next = 1'b0;
      REQ_STATUS_TGL: status_lit_next = !status_lit;
      REQ_IDLE_START: begin
        running_next      = 1'b1;
        fast_stage_next   = 1'b0;
        pass_count_next   = '0;
        led_position_next = '0;
        tick_count_next   = '0;
        step_period_next  = cfg.start_period;
      end
      REQ_IDLE_STOP: begin
        running_next    = 1'b0;
        front_leds_next = '0;
      end
      default: ;
    endcase

    if (req_type != REQ_TICK && activity) begin
      pending_next = 1'b1;
    end
  end

  assign res_next.led_map     = {status_lit_next, front_leds_next};
  assign res_next.idle_active = running_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_leds   <= '0;
      status_lit   <= 1'b0;
      running      <= 1'b0;
      fast_stage   <= 1'b0;
      pass_count   <= '0;
      led_position <= '0;
      tick_count   <= '0;
      step_period  <= START_PERIOD_RST;
      pending      <= 1'b0;
    end else if (fire) begin
      front_leds   <= front_leds_next;
      status_lit   <= status_lit_next;
      running      <= running_next;
      fast_stage   <= fast_stage_next;
      pass_count   <= pass_count_next;
      led_position <= led_position_next;
      tick_count   <= tick_count_next;
      step_period  <= step_period_next;
      pending      <= pending_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/led_bank_with_idle_chaser_top.sv
// Top level of the LED bank with idle chaser.
//
// The req channel carries one beat per tick or command: req_type, front_mask
// and activity. For every request beat the res channel returns exactly one
// beat giving the LED map (front LEDs in bits 0-7, status LED in bit 8) and
// whether the idle chaser runs, as they stand after that request.
// The result beat is registered and is valid in the cycle after the
// request is taken. Throughput is one beat per cycle while res is ready,
// set by the single state update feeding the state and result registers.
// The cfg port writes the timing registers (start period, decrement,
// threshold, minimum period, passes to fast stage). The user writes them
// only while the block is idle; the block does not enforce it. Reset clears
// the LEDs, stops the chaser and loads the default timing. When the receiver
// stalls, the held result stays on res and req.ready drops until it is taken;
// a new request is taken in the same cycle as the held result leaves.
`default_nettype none

module led_bank_with_idle_chaser_top
  import lbic_pkg::*;
#(
  parameter int NUM_LEDS = LBIC_NUM_LEDS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lbic_req_if.sink                   req,
  lbic_res_if.source                 res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  res_t res_next;
  logic fire;
  logic out_valid;
  res_t out_res;

  assign req.ready = !out_valid || res.ready;
  assign fire      = req.valid && req.ready;

  lbic_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  lbic_core #(
    .NUM_LEDS(NUM_LEDS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req_type  (req.req_type),
    .front_mask(req.front_mask),
    .activity  (req.activity),
    .cfg       (cfg),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.led_map     = out_res.led_map;
  assign res.idle_active = out_res.idle_active;

endmodule

`default_nettype wire

// File: verif/led_bank_with_idle_chaser_top_test.sv
// Testbench for the LED bank with idle chaser: predicted panel state checked per result beat.
`default_nettype none

class led_panel_scoreboard;
  lbic_pkg::cfg_t cfg;
  lbic_pkg::res_t expected_panel[$];
  int             failures;

  logic [7:0]  front;
  logic        status;
  logic        chaser_on;
  logic        fast;
  logic [3:0]  passes;
  logic [3:0]  pos;
  logic [15:0] ticks;
  logic [15:0] period;
  logic        held_activity;

  function new();
    cfg.start_period        = lbic_pkg::START_PERIOD_RST;
    cfg.period_decrement    = lbic_pkg::PERIOD_DEC_RST;
    cfg.decrement_threshold = lbic_pkg::DEC_THRESH_RST;
    cfg.min_period          = lbic_pkg::MIN_PERIOD_RST;
    cfg.accel_passes        = lbic_pkg::ACCEL_PASSES_RST;
    front         = '0;
    status        = 1'b0;
    chaser_on     = 1'b0;
    fast          = 1'b0;
    passes        = '0;
    pos           = '0;
    ticks         = '0;
    period        = lbic_pkg::START_PERIOD_RST;
    held_activity = 1'b0;
    failures      = 0;
  endfunction

  function void set_register(logic [lbic_pkg::CFG_IDX_W-1:0] idx,
                             logic [lbic_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lbic_pkg::CFG_START_PERIOD: cfg.start_period        = data;
      lbic_pkg::CFG_PERIOD_DEC:   cfg.period_decrement    = data;
      lbic_pkg::CFG_DEC_THRESH:   cfg.decrement_threshold = data;
      lbic_pkg::CFG_MIN_PERIOD:   cfg.min_period          = data;
      lbic_pkg::CFG_ACCEL_PASSES: cfg.accel_passes        = data[3:0];
      default: ;
    endcase
  endfunction

  function void finish_pass();
    if (fast) return;
    passes = passes + 4'd1;
    if (period > cfg.decrement_threshold && cfg.period_decrement < period)
      period = period - cfg.period_decrement;
    else
      period = cfg.min_period;
    if (passes >= cfg.accel_passes) begin
      fast   = 1'b1;
      period = cfg.min_period;
    end
  endfunction

  function void advance_chaser(logic seen);
    if (!chaser_on) return;
    if (seen) begin
      chaser_on = 1'b0;
      front     = '0;
      return;
    end
    ticks = ticks + 16'd1;
    if (ticks < period) return;
    ticks = '0;
    if (pos >= lbic_pkg::LBIC_NUM_LEDS) begin
      pos = '0;
      finish_pass();
    end
    front = (pos < 4'd8) ? (8'd1 << pos) : 8'd0;
    pos   = pos + 4'd1;
  endfunction

  function void note_request(logic [3:0] kind, logic [7:0] mask, logic act);
    lbic_pkg::res_t exp;
    case (kind)
      lbic_pkg::REQ_TICK: begin
        advance_chaser(act | held_activity);
        held_activity = 1'b0;
      end
      lbic_pkg::REQ_ON:         front  = front | mask;
      lbic_pkg::REQ_OFF:        front  = front & ~mask;
      lbic_pkg::REQ_TOGGLE:     front  = front ^ mask;
      lbic_pkg::REQ_LOAD:       front  = mask;
      lbic_pkg::REQ_STATUS_ON:  status = 1'b1;
      lbic_pkg::REQ_STATUS_OFF: status = 1'b0;
      lbic_pkg::REQ_STATUS_TGL: status = ~status;
      lbic_pkg::REQ_IDLE_START: begin
        chaser_on = 1'b1;
        fast      = 1'b0;
        passes    = '0;
        pos       = '0;
        ticks     = '0;
        period    = cfg.start_period;
      end
      lbic_pkg::REQ_IDLE_STOP: begin
        chaser_on = 1'b0;
        front     = '0;
      end
      default: ;
    endcase
    if (kind != lbic_pkg::REQ_TICK && act) held_activity = 1'b1;
    exp.led_map     = {status, front};
    exp.idle_active = chaser_on;
    expected_panel.push_back(exp);
  endfunction

  function void check_result(lbic_pkg::res_t got);
    lbic_pkg::res_t exp;
    if (expected_panel.size() == 0) begin
      $display("%0t: result beat with none expected: led_map %h idle_active %b",
               $time, got.led_map, got.idle_active);
      failures++;
      return;
    end
    exp = expected_panel.pop_front();
    if (exp.led_map !== got.led_map) begin
      $display("%0t: led_map expected %h actual %h", $time, exp.led_map, got.led_map);
      failures++;
    end
    if (exp.idle_active !== got.idle_active) begin
      $display("%0t: idle_active expected %b actual %b",
               $time, exp.idle_active, got.idle_active);
      failures++;
    end
  endfunction

  function int pending();
    return expected_panel.size();
  endfunction
endclass

module led_bank_with_idle_chaser_top_test;
  import lbic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   CYCLE_LIMIT    = 400000;
  localparam int                   PHASES         = 10;
  localparam int                   PHASE_ITEMS    = 112;
  localparam logic [3:0]           REQ_SPARE_LO   = 4'd10;
  localparam logic [3:0]           REQ_SPARE_HI   = 4'd15;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI   = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    idling = 1'b1;
  int                    cycles = 0;
  int                    stall_left = 0;
  led_panel_scoreboard   sb = new();

  lbic_req_if req_ch();
  lbic_res_if res_ch();

  led_bank_with_idle_chaser_top uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("led_bank_with_idle_chaser_top: mismatch");
      $finish;
    end
  end

  // result side: check beats, stall in bursts
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        sb.check_result('{led_map: res_ch.led_map, idle_active: res_ch.idle_active});
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [3:0] kind, input logic [7:0] mask, input logic act);
    if (idling && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.front_mask <= mask;
    req_ch.activity   <= act;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, mask, act);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s, input bit with_spare);
    write_reg(CFG_START_PERIOD, s.start_period);
    write_reg(CFG_PERIOD_DEC, s.period_decrement);
    write_reg(CFG_DEC_THRESH, s.decrement_threshold);
    write_reg(CFG_MIN_PERIOD, s.min_period);
    write_reg(CFG_ACCEL_PASSES, {12'd0, s.accel_passes});
    if (with_spare)
      write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 16'hffff);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      send_item(REQ_TICK, 8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
    else if (r < 74 || (!sb.chaser_on && r < 85))
      send_item(REQ_IDLE_START, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    else if (r < 76)
      send_item(REQ_IDLE_STOP, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    else if (r < 80)
      send_item(4'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), 8'($urandom_range(0, 255)),
                $urandom_range(0, 9) == 0);
    else
      send_item(4'($urandom_range(REQ_ON, REQ_STATUS_TGL)), 8'($urandom_range(0, 255)),
                $urandom_range(0, 9) == 0);
  endtask

  initial begin
    cfg_t s;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_TICK;
    req_ch.front_mask <= '0;
    req_ch.activity   <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_START_PERIOD;
    cfg_data          <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: every request at reset timing
    send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_ON, 8'hff, 1'b0);
    send_item(REQ_OFF, 8'h0f, 1'b0);
    send_item(REQ_TOGGLE, 8'hff, 1'b0);
    send_item(REQ_LOAD, 8'h00, 1'b0);
    send_item(REQ_LOAD, 8'ha5, 1'b0);
    send_item(REQ_STATUS_ON, 8'h00, 1'b0);
    send_item(REQ_STATUS_TGL, 8'h00, 1'b0);
    send_item(REQ_STATUS_TGL, 8'hff, 1'b0);
    send_item(REQ_STATUS_OFF, 8'h00, 1'b0);
    for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
      send_item(4'(k), 8'hff, 1'b1);
    send_item(REQ_IDLE_STOP, 8'hff, 1'b0);
    send_item(REQ_TICK, 8'hff, 1'b0);
    send_item(REQ_IDLE_START, 8'h00, 1'b0);
    send_item(REQ_LOAD, 8'h3c, 1'b0);
    send_item(REQ_IDLE_START, 8'h00, 1'b0);
    send_item(REQ_TICK, 8'h00, 1'b1);
    send_item(REQ_IDLE_START, 8'h00, 1'b0);
    send_item(REQ_STATUS_ON, 8'h00, 1'b1);
    send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_IDLE_START, 8'h00, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: s = '{16'd1, 16'd0, 16'd0, 16'd1, 4'd1};
        1: s = '{16'd0, 16'd0, 16'd0, 16'd0, 4'd15};
        2: s = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'd15};
        3: s = '{16'd12, 16'd20, 16'd3, 16'd2, 4'd3};
        4: s = '{16'd9, 16'd2, 16'd4, 16'd1, 4'd4};
        5: s = '{16'd3, 16'd1, 16'd0, 16'd2, 4'd0};
        default: begin
          s.start_period        = 16'($urandom_range(1, 10));
          s.period_decrement    = 16'($urandom_range(0, 4));
          s.decrement_threshold = 16'($urandom_range(0, 10));
          s.min_period          = 16'($urandom_range(1, 3));
          s.accel_passes        = 4'($urandom_range(1, 15));
        end
      endcase
      load_settings(s, p == 0);
      idling = (p < PHASES - 1);
      send_item(REQ_IDLE_START, 8'($urandom_range(0, 255)), 1'b0);
      for (int n = 1; n < PHASE_ITEMS; n++)
        random_item();
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("led_bank_with_idle_chaser_top: match");
    end else begin
      $display("led_bank_with_idle_chaser_top: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: files.f
hw/rtl/lbic_pkg.sv
hw/rtl/lbic_if.sv
hw/rtl/lbic_cfg_regs.sv
hw/rtl/lbic_core.sv
hw/rtl/led_bank_with_idle_chaser_top.sv
verif/led_bank_with_idle_chaser_top_test.sv
